// ----- src/ggbi_pkg.sv -----
// Shared types, widths and codes for the geoid grid bilinear interpolator.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package ggbi_pkg;

    localparam int AREAS_DEF           = 4;
    localparam int AREA_WORDS_LOG2_DEF = 18;

    localparam int COORD_W   = 32;             // Q9.22 coordinates
    localparam int STEP_W    = 31;             // Q9.22 grid spacing
    localparam int COL_W     = 12;             // column and row counts
    localparam int WADDR_W   = 18;             // word_address port width
    localparam int WORD_W    = 32;             // grid word, Q24.8 mm
    localparam int FRAC_W    = 16;             // cell fraction, Q0.16
    localparam int DQ_W      = 32;             // point minus origin
    localparam int QUOT_W    = DQ_W + FRAC_W;  // quotient with fraction bits
    localparam int DIV_STEPS = QUOT_W;         // one quotient bit per step
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);
    localparam int DPROD_W   = COL_W + 1 + STEP_W + 1;  // bound product
    localparam int MUL_A_W   = 49;             // widest difference operand
    localparam int MUL_B_W   = FRAC_W + 1;     // fraction, zero extended
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int UV_W      = 49;
    localparam int ROUND_SH  = 2 * FRAC_W + 8; // 2^40 per millimetre
    localparam int PADDR_W   = 3;
    localparam int CNT_W     = 3;

    localparam logic signed [COORD_W-1:0] ONE_DEGREE = 32'sh0040_0000;
    localparam logic signed [31:0]        FAIL_MM    = -32'sd999000;
    localparam logic [PADDR_W-1:0]        ADDR_AREA_COUNT = 3'd0;

    typedef enum logic [1:0] {
        OP_WORD  = 2'd0,
        OP_DESC  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    // Result kinds double as the status code on the port.
    typedef enum logic [1:0] {
        RES_OK    = 2'd0,
        RES_OUT   = 2'd1,
        RES_RANGE = 2'd2,
        RES_LOAD  = 2'd3
    } res_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_UX,
        MUL_VX,
        MUL_WY
    } mul_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_U,
        ACC_V,
        ACC_W
    } acc_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DESC,
        S_LOAD,
        S_SEARCH,
        S_DIV,
        S_BASE,
        S_ADDR,
        S_CHK,
        S_READ,
        S_MU,
        S_MV,
        S_MW,
        S_MY,
        S_W,
        S_FIN
    } state_t;

    typedef struct packed {
        logic       latch;
        logic       desc_mul;
        logic       load_wr;
        logic       div_init;
        logic       div_step;
        logic       base_mul;
        logic       addr_calc;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_idx;
        mul_t       mul_op;
        acc_t       acc_op;
        logic       emit;
        res_t       res;
    } cmd_t;

    typedef struct packed {
        logic search_end;
        logic hit;
        logic range_bad;
    } stat_t;

endpackage

`default_nettype wire

// ----- src/ggbi_div.sv -----
// Restoring divider, one quotient bit per step: {dividend, 16 zero bits} / divisor.
// Depends on ggbi_pkg for widths.
`default_nettype none

module ggbi_div (
    input  wire logic                        clk,
    input  wire logic                        init,
    input  wire logic                        step,
    input  wire logic [ggbi_pkg::DQ_W-1:0]   dividend,
    input  wire logic [ggbi_pkg::STEP_W-1:0] divisor,
    output logic      [ggbi_pkg::QUOT_W-1:0] quot
);

    logic [ggbi_pkg::STEP_W-1:0] rem_reg, rem_next;
    logic [ggbi_pkg::QUOT_W-1:0] q_reg, q_next;
    logic [ggbi_pkg::STEP_W:0]   rem_sh;
    logic                        ge;

    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[ggbi_pkg::QUOT_W-1]};
        ge       = rem_sh >= {1'b0, divisor};
        rem_next = ge ? ggbi_pkg::STEP_W'(rem_sh - {1'b0, divisor})
                      : ggbi_pkg::STEP_W'(rem_sh);
        q_next   = {q_reg[ggbi_pkg::QUOT_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            rem_reg <= '0;
            q_reg   <= {dividend, {ggbi_pkg::FRAC_W{1'b0}}};
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign quot = q_reg;

endmodule

`default_nettype wire

// ----- src/ggbi_dp.sv -----
// Datapath: area descriptors, grid memory, two dividers, multiplier and result registers.
// Depends on ggbi_pkg and ggbi_div; steered by ggbi_ctrl through cmd_t.
`default_nettype none

module ggbi_dp #(
    parameter int AREAS           = ggbi_pkg::AREAS_DEF,
    parameter int AREA_WORDS_LOG2 = ggbi_pkg::AREA_WORDS_LOG2_DEF,
    parameter int AW              = (AREAS > 1) ? $clog2(AREAS) : 1,
    parameter int CW              = $clog2(AREAS + 1)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ggbi_pkg::cmd_t                     cmd,
    input  wire logic [CW-1:0]                      area_idx,
    output ggbi_pkg::stat_t                         stat,
    input  wire logic [ggbi_pkg::CNT_W-1:0]         area_count,
    input  wire logic [1:0]                         opcode,
    input  wire logic signed [ggbi_pkg::COORD_W-1:0] query_lon,
    input  wire logic signed [ggbi_pkg::COORD_W-1:0] query_lat,
    input  wire logic [1:0]                         area_select,
    input  wire logic signed [ggbi_pkg::COORD_W-1:0] origin_lon,
    input  wire logic signed [ggbi_pkg::COORD_W-1:0] origin_lat,
    input  wire logic [ggbi_pkg::COL_W-1:0]         column_count,
    input  wire logic [ggbi_pkg::COL_W-1:0]         row_count,
    input  wire logic [ggbi_pkg::STEP_W-1:0]        column_spacing,
    input  wire logic [ggbi_pkg::STEP_W-1:0]        row_spacing,
    input  wire logic [ggbi_pkg::WADDR_W-1:0]       word_address,
    input  wire logic signed [ggbi_pkg::WORD_W-1:0] word_value,
    output logic                                    done,
    output logic [1:0]                              status,
    output logic signed [31:0]                      height_mm,
    output logic [1:0]                              area_hit
);

    localparam int L     = AREA_WORDS_LOG2;
    localparam int MW    = AW + L;
    localparam int DEPTH = AREAS << L;
    localparam int BW    = L + ggbi_pkg::COL_W + 3;
    localparam int SW    = ggbi_pkg::COORD_W + 15;

    // latched transaction
    ggbi_pkg::opcode_t                       op_reg;
    logic signed [ggbi_pkg::COORD_W-1:0]     x_reg, y_reg, ox_reg, oy_reg;
    logic [1:0]                              sel_reg;
    logic [ggbi_pkg::COL_W-1:0]              nc_reg, nr_reg;
    logic [ggbi_pkg::STEP_W-1:0]             dx_reg, dy_reg;
    logic [ggbi_pkg::WADDR_W-1:0]            waddr_reg;
    logic signed [ggbi_pkg::WORD_W-1:0]      wval_reg;

    // area descriptors
    logic                                    valid_reg [AREAS];
    logic signed [ggbi_pkg::COORD_W-1:0]     west_reg [AREAS];
    logic signed [ggbi_pkg::COORD_W-1:0]     east_reg [AREAS];
    logic signed [ggbi_pkg::COORD_W-1:0]     south_reg [AREAS];
    logic signed [ggbi_pkg::COORD_W-1:0]     north_reg [AREAS];
    logic [ggbi_pkg::STEP_W-1:0]             lstep_reg [AREAS];
    logic [ggbi_pkg::STEP_W-1:0]             bstep_reg [AREAS];
    logic [ggbi_pkg::COL_W-1:0]              cols_reg [AREAS];

    logic signed [ggbi_pkg::WORD_W-1:0]      grid_mem [DEPTH];
    logic signed [ggbi_pkg::WORD_W-1:0]      rd_data_reg;

    logic signed [ggbi_pkg::DPROD_W-1:0]     ep_reg, np_reg;
    logic [L+ggbi_pkg::COL_W:0]              bprod_reg;
    logic                                    big_reg;
    logic [BW-1:0]                           base_reg;
    logic signed [ggbi_pkg::WORD_W-1:0]      t_reg [4];
    logic signed [ggbi_pkg::PROD_W-1:0]      prod_reg;
    logic signed [ggbi_pkg::UV_W-1:0]        u_reg, v_reg;
    logic signed [ggbi_pkg::PROD_W-1:0]      w_reg;

    logic                                    done_reg;
    ggbi_pkg::res_t                          res_reg;
    logic signed [31:0]                      height_reg;
    logic [1:0]                              hit_reg;

    logic [AW-1:0]                           ai;
    logic [CW-1:0]                           lim;
    logic [ggbi_pkg::DQ_W:0]                 dqx, dqy;
    logic [ggbi_pkg::QUOT_W-1:0]             quot_x, quot_y;
    logic [ggbi_pkg::DQ_W:0]                 qx1, qy1;
    logic [ggbi_pkg::COL_W:0]                nc1;
    logic [BW-1:0]                           end_addr;
    logic [L-1:0]                            rd_off, corner_off;
    logic [MW-1:0]                           rd_addr, wr_addr;
    logic                                    sel_ok;
    logic signed [SW-1:0]                    east_full, north_full;
    logic signed [ggbi_pkg::COORD_W-1:0]     east_sat, north_sat;
    logic signed [ggbi_pkg::MUL_A_W-1:0]     mul_a;
    logic [ggbi_pkg::FRAC_W-1:0]             mul_b;
    logic [ggbi_pkg::PROD_W-1:0]             mag;
    logic [ggbi_pkg::PROD_W:0]               mag_r;
    logic [31:0]                             rnd;
    logic signed [31:0]                      height_ok;

    assign ai  = AW'(area_idx);
    assign lim = (32'(area_count) > AREAS) ? CW'(AREAS) : CW'(area_count);

    always_comb
    begin
        stat.search_end = area_idx >= lim;
        stat.hit        = valid_reg[ai]
                       && (west_reg[ai] < x_reg) && (x_reg < east_reg[ai])
                       && (south_reg[ai] < y_reg) && (y_reg < north_reg[ai]);
        end_addr        = base_reg + BW'(cols_reg[ai]) + BW'(2);
        stat.range_bad  = big_reg || (end_addr[BW-1:L] != '0);
    end

    // point offsets from the origin; positive inside a matched area
    assign dqx = {x_reg[ggbi_pkg::COORD_W-1], x_reg} - {west_reg[ai][ggbi_pkg::COORD_W-1], west_reg[ai]};
    assign dqy = {y_reg[ggbi_pkg::COORD_W-1], y_reg} - {south_reg[ai][ggbi_pkg::COORD_W-1], south_reg[ai]};

    ggbi_div u_div_x (
        .clk      (clk),
        .init     (cmd.div_init),
        .step     (cmd.div_step),
        .dividend (dqx[ggbi_pkg::DQ_W-1:0]),
        .divisor  (lstep_reg[ai]),
        .quot     (quot_x)
    );

    ggbi_div u_div_y (
        .clk      (clk),
        .init     (cmd.div_init),
        .step     (cmd.div_step),
        .dividend (dqy[ggbi_pkg::DQ_W-1:0]),
        .divisor  (bstep_reg[ai]),
        .quot     (quot_y)
    );

    assign qx1 = {1'b0, quot_x[ggbi_pkg::QUOT_W-1:ggbi_pkg::FRAC_W]} + (ggbi_pkg::DQ_W+1)'(1);
    assign qy1 = {1'b0, quot_y[ggbi_pkg::QUOT_W-1:ggbi_pkg::FRAC_W]} + (ggbi_pkg::DQ_W+1)'(1);
    assign nc1 = {1'b0, cols_reg[ai]} + (ggbi_pkg::COL_W+1)'(1);

    // latch inputs on accept
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= ggbi_pkg::opcode_t'(opcode);
            x_reg     <= query_lon;
            y_reg     <= query_lat;
            sel_reg   <= area_select;
            ox_reg    <= origin_lon;
            oy_reg    <= origin_lat;
            nc_reg    <= column_count;
            nr_reg    <= row_count;
            dx_reg    <= column_spacing;
            dy_reg    <= row_spacing;
            waddr_reg <= word_address;
            wval_reg  <= word_value;
        end
    end

    // descriptor bounds: east = origin + (cols-1)*step - one degree, saturated
    always_ff @(posedge clk)
    begin
        if (cmd.desc_mul)
        begin
            ep_reg <= $signed({1'b0, nc_reg} - (ggbi_pkg::COL_W+1)'(1)) * $signed({1'b0, dx_reg});
            np_reg <= $signed({1'b0, nr_reg} - (ggbi_pkg::COL_W+1)'(1)) * $signed({1'b0, dy_reg});
        end
    end

    assign east_full  = SW'(ox_reg) + SW'(ep_reg) - SW'(ggbi_pkg::ONE_DEGREE);
    assign north_full = SW'(oy_reg) + SW'(np_reg);

    always_comb
    begin
        if (east_full > SW'(32'sh7FFF_FFFF))
            east_sat = 32'sh7FFF_FFFF;
        else if (east_full < -SW'(33'sh0_8000_0000))
            east_sat = 32'sh8000_0000;
        else
            east_sat = ggbi_pkg::COORD_W'(east_full);
        if (north_full > SW'(32'sh7FFF_FFFF))
            north_sat = 32'sh7FFF_FFFF;
        else if (north_full < -SW'(33'sh0_8000_0000))
            north_sat = 32'sh8000_0000;
        else
            north_sat = ggbi_pkg::COORD_W'(north_full);
    end

    assign sel_ok = 32'(sel_reg) < AREAS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AREAS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (cmd.load_wr && op_reg == ggbi_pkg::OP_DESC && sel_ok)
        begin
            valid_reg[AW'(sel_reg)] <= (dx_reg != '0) && (dy_reg != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && op_reg == ggbi_pkg::OP_DESC && sel_ok)
        begin
            west_reg[AW'(sel_reg)]  <= ox_reg;
            south_reg[AW'(sel_reg)] <= oy_reg;
            east_reg[AW'(sel_reg)]  <= east_sat;
            north_reg[AW'(sel_reg)] <= north_sat;
            lstep_reg[AW'(sel_reg)] <= dx_reg;
            bstep_reg[AW'(sel_reg)] <= dy_reg;
            cols_reg[AW'(sel_reg)]  <= nc_reg;
        end
    end

    // cell base address = (row+1)*(cols+1) + (col+1)
    always_ff @(posedge clk)
    begin
        if (cmd.base_mul)
        begin
            bprod_reg <= qy1[L-1:0] * nc1;
            big_reg   <= (qx1[ggbi_pkg::DQ_W:L] != '0) || (qy1[ggbi_pkg::DQ_W:L] != '0);
        end
        if (cmd.addr_calc)
        begin
            base_reg <= BW'(bprod_reg) + BW'(qx1[L-1:0]);
        end
    end

    // grid memory
    assign wr_addr = {AW'(sel_reg), L'(waddr_reg)};

    always_comb
    begin
        unique case (cmd.rd_sel)
            2'd0:    corner_off = '0;
            2'd1:    corner_off = L'(1);
            2'd2:    corner_off = L'(nc1);
            default: corner_off = L'(nc1) + L'(1);
        endcase
        rd_off  = base_reg[L-1:0] + corner_off;
        rd_addr = {ai, rd_off};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && op_reg == ggbi_pkg::OP_WORD && sel_ok)
        begin
            grid_mem[wr_addr] <= wval_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    // corners land in order t1, t3, t2, t4
    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            t_reg[cmd.cap_idx] <= rd_data_reg;
        end
    end

    // bilinear: u = t1*2^16 + (t3-t1)*fx, v likewise, w = u*2^16 + (v-u)*fy
    always_comb
    begin
        unique case (cmd.mul_op)
            ggbi_pkg::MUL_UX:
            begin
                mul_a = ggbi_pkg::MUL_A_W'(t_reg[1]) - ggbi_pkg::MUL_A_W'(t_reg[0]);
                mul_b = quot_x[ggbi_pkg::FRAC_W-1:0];
            end
            ggbi_pkg::MUL_VX:
            begin
                mul_a = ggbi_pkg::MUL_A_W'(t_reg[3]) - ggbi_pkg::MUL_A_W'(t_reg[2]);
                mul_b = quot_x[ggbi_pkg::FRAC_W-1:0];
            end
            ggbi_pkg::MUL_WY:
            begin
                mul_a = ggbi_pkg::MUL_A_W'(v_reg) - ggbi_pkg::MUL_A_W'(u_reg);
                mul_b = quot_y[ggbi_pkg::FRAC_W-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_op != ggbi_pkg::MUL_NONE)
        begin
            prod_reg <= mul_a * $signed({1'b0, mul_b});
        end
        unique case (cmd.acc_op)
            ggbi_pkg::ACC_U: u_reg <= (ggbi_pkg::UV_W'(t_reg[0]) <<< ggbi_pkg::FRAC_W)
                                      + ggbi_pkg::UV_W'(prod_reg);
            ggbi_pkg::ACC_V: v_reg <= (ggbi_pkg::UV_W'(t_reg[2]) <<< ggbi_pkg::FRAC_W)
                                      + ggbi_pkg::UV_W'(prod_reg);
            ggbi_pkg::ACC_W: w_reg <= (ggbi_pkg::PROD_W'(u_reg) <<< ggbi_pkg::FRAC_W) + prod_reg;
            default: ;
        endcase
    end

    // round half away from zero to whole millimetres
    always_comb
    begin
        mag       = w_reg[ggbi_pkg::PROD_W-1] ? ggbi_pkg::PROD_W'(-w_reg)
                                              : ggbi_pkg::PROD_W'(w_reg);
        mag_r     = {1'b0, mag} + ((ggbi_pkg::PROD_W+1)'(1) << (ggbi_pkg::ROUND_SH - 1));
        rnd       = 32'(mag_r >> ggbi_pkg::ROUND_SH);
        height_ok = w_reg[ggbi_pkg::PROD_W-1] ? -$signed(rnd) : $signed(rnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg <= cmd.res;
            unique case (cmd.res)
                ggbi_pkg::RES_OK:
                begin
                    height_reg <= height_ok;
                    hit_reg    <= 2'(area_idx);
                end
                ggbi_pkg::RES_RANGE:
                begin
                    height_reg <= ggbi_pkg::FAIL_MM;
                    hit_reg    <= 2'(area_idx);
                end
                ggbi_pkg::RES_OUT:
                begin
                    height_reg <= ggbi_pkg::FAIL_MM;
                    hit_reg    <= '0;
                end
                default:
                begin
                    height_reg <= '0;
                    hit_reg    <= '0;
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign status    = res_reg;
    assign height_mm = height_reg;
    assign area_hit  = hit_reg;

endmodule

`default_nettype wire

// ----- src/ggbi_ctrl.sv -----
// Controller state machine: sequences loads, area search, division, corner reads and blend.
// Depends on ggbi_pkg; drives ggbi_dp through cmd_t and reads stat_t back.
`default_nettype none

module ggbi_ctrl #(
    parameter int AREAS = ggbi_pkg::AREAS_DEF,
    parameter int CW    = $clog2(AREAS + 1)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [1:0]      opcode,
    input  wire ggbi_pkg::stat_t stat,
    output ggbi_pkg::cmd_t       cmd,
    output logic [CW-1:0]        area_idx,
    output logic                 busy
);

    ggbi_pkg::state_t                  state_reg, state_next;
    logic [CW-1:0]                     idx_reg, idx_next;
    logic [ggbi_pkg::STEP_CNT_W-1:0]   step_reg, step_next;
    logic                              accept;

    assign accept = start && (state_reg == ggbi_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ggbi_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    priority case (ggbi_pkg::opcode_t'(opcode))
                        ggbi_pkg::OP_QUERY: state_next = ggbi_pkg::S_SEARCH;
                        ggbi_pkg::OP_DESC:  state_next = ggbi_pkg::S_DESC;
                        default:            state_next = ggbi_pkg::S_LOAD;
                    endcase
                end
            end
            ggbi_pkg::S_DESC: state_next = ggbi_pkg::S_LOAD;
            ggbi_pkg::S_LOAD: state_next = ggbi_pkg::S_IDLE;
            ggbi_pkg::S_SEARCH:
            begin
                if (stat.search_end)
                    state_next = ggbi_pkg::S_IDLE;
                else if (stat.hit)
                begin
                    state_next = ggbi_pkg::S_DIV;
                    step_next  = '0;
                end
                else
                    idx_next = idx_reg + CW'(1);
            end
            ggbi_pkg::S_DIV:
            begin
                step_next = step_reg + ggbi_pkg::STEP_CNT_W'(1);
                if (step_reg == ggbi_pkg::STEP_CNT_W'(ggbi_pkg::DIV_STEPS - 1))
                    state_next = ggbi_pkg::S_BASE;
            end
            ggbi_pkg::S_BASE: state_next = ggbi_pkg::S_ADDR;
            ggbi_pkg::S_ADDR: state_next = ggbi_pkg::S_CHK;
            ggbi_pkg::S_CHK:
            begin
                step_next = '0;
                state_next = stat.range_bad ? ggbi_pkg::S_IDLE : ggbi_pkg::S_READ;
            end
            ggbi_pkg::S_READ:
            begin
                step_next = step_reg + ggbi_pkg::STEP_CNT_W'(1);
                if (step_reg == ggbi_pkg::STEP_CNT_W'(4))
                    state_next = ggbi_pkg::S_MU;
            end
            ggbi_pkg::S_MU: state_next = ggbi_pkg::S_MV;
            ggbi_pkg::S_MV: state_next = ggbi_pkg::S_MW;
            ggbi_pkg::S_MW: state_next = ggbi_pkg::S_MY;
            ggbi_pkg::S_MY: state_next = ggbi_pkg::S_W;
            ggbi_pkg::S_W:  state_next = ggbi_pkg::S_FIN;
            ggbi_pkg::S_FIN: state_next = ggbi_pkg::S_IDLE;
            default: state_next = ggbi_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.mul_op = ggbi_pkg::MUL_NONE;
        cmd.acc_op = ggbi_pkg::ACC_NONE;
        cmd.res    = ggbi_pkg::RES_LOAD;
        unique case (state_reg)
            ggbi_pkg::S_IDLE: cmd.latch = accept;
            ggbi_pkg::S_DESC: cmd.desc_mul = 1'b1;
            ggbi_pkg::S_LOAD:
            begin
                cmd.load_wr = 1'b1;
                cmd.emit    = 1'b1;
                cmd.res     = ggbi_pkg::RES_LOAD;
            end
            ggbi_pkg::S_SEARCH:
            begin
                cmd.div_init = 1'b1;
                cmd.emit     = stat.search_end;
                cmd.res      = ggbi_pkg::RES_OUT;
            end
            ggbi_pkg::S_DIV:  cmd.div_step  = 1'b1;
            ggbi_pkg::S_BASE: cmd.base_mul  = 1'b1;
            ggbi_pkg::S_ADDR: cmd.addr_calc = 1'b1;
            ggbi_pkg::S_CHK:
            begin
                cmd.emit = stat.range_bad;
                cmd.res  = ggbi_pkg::RES_RANGE;
            end
            ggbi_pkg::S_READ:
            begin
                // issue four reads, capture each on the step after its read
                cmd.rd_en   = step_reg < ggbi_pkg::STEP_CNT_W'(4);
                cmd.rd_sel  = step_reg[1:0];
                cmd.cap_en  = step_reg != '0;
                cmd.cap_idx = 2'(step_reg - ggbi_pkg::STEP_CNT_W'(1));
            end
            ggbi_pkg::S_MU: cmd.mul_op = ggbi_pkg::MUL_UX;
            ggbi_pkg::S_MV:
            begin
                cmd.mul_op = ggbi_pkg::MUL_VX;
                cmd.acc_op = ggbi_pkg::ACC_U;
            end
            ggbi_pkg::S_MW: cmd.acc_op = ggbi_pkg::ACC_V;
            ggbi_pkg::S_MY: cmd.mul_op = ggbi_pkg::MUL_WY;
            ggbi_pkg::S_W:  cmd.acc_op = ggbi_pkg::ACC_W;
            ggbi_pkg::S_FIN:
            begin
                cmd.emit = 1'b1;
                cmd.res  = ggbi_pkg::RES_OK;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ggbi_pkg::S_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    assign area_idx = idx_reg;
    assign busy     = state_reg != ggbi_pkg::S_IDLE;

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == ggbi_pkg::S_IDLE)
        else $error("emit not followed by idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ggbi_pkg::S_DIV |-> step_reg < ggbi_pkg::STEP_CNT_W'(ggbi_pkg::DIV_STEPS))
        else $error("divider step count overrun");

    a_idx_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ggbi_pkg::S_DIV || state_reg == ggbi_pkg::S_READ) |=> $stable(idx_reg))
        else $error("area index moved during query");

endmodule

`default_nettype wire

// ----- src/geoid_grid_bilinear_interpolator.sv -----
// Top level: APB configuration register, controller and datapath.
// Depends on ggbi_pkg, ggbi_ctrl and ggbi_dp.
//
// channel   handshake             payload
// input     start / busy          opcode, query_*, area_select, origin_*, *_count,
//                                 *_spacing, word_address, word_value
// result    done (one cycle)      status, height_mm, area_hit
// config    psel/penable/pwrite   paddr, pwdata, prdata, pready (always high)
//
// A grid word load goes straight to S_LOAD; a descriptor load passes through S_DESC first.
// A query searches the areas in order, then runs the two 48-step restoring dividers and
// makes four corner reads through the single grid memory read port.
// A new transaction is taken in the cycle done is high. Reset clears the
// controller, area valid bits and area_count; grid memory needs no clearing.
// The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none

module geoid_grid_bilinear_interpolator #(
    parameter int AREAS           = ggbi_pkg::AREAS_DEF,
    parameter int AREA_WORDS_LOG2 = ggbi_pkg::AREA_WORDS_LOG2_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ggbi_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          opcode,
    input  wire logic signed [ggbi_pkg::COORD_W-1:0] query_lon,
    input  wire logic signed [ggbi_pkg::COORD_W-1:0] query_lat,
    input  wire logic [1:0]                          area_select,
    input  wire logic signed [ggbi_pkg::COORD_W-1:0] origin_lon,
    input  wire logic signed [ggbi_pkg::COORD_W-1:0] origin_lat,
    input  wire logic [ggbi_pkg::COL_W-1:0]          column_count,
    input  wire logic [ggbi_pkg::COL_W-1:0]          row_count,
    input  wire logic [ggbi_pkg::STEP_W-1:0]         column_spacing,
    input  wire logic [ggbi_pkg::STEP_W-1:0]         row_spacing,
    input  wire logic [ggbi_pkg::WADDR_W-1:0]        word_address,
    input  wire logic signed [ggbi_pkg::WORD_W-1:0]  word_value,
    output logic                                     done,
    output logic [1:0]                               status,
    output logic signed [31:0]                       height_mm,
    output logic [1:0]                               area_hit
);

    localparam int AW = (AREAS > 1) ? $clog2(AREAS) : 1;
    localparam int CW = $clog2(AREAS + 1);

    logic [ggbi_pkg::CNT_W-1:0] area_count_reg;
    logic                       cfg_sel;
    ggbi_pkg::cmd_t             cmd;
    ggbi_pkg::stat_t            stat;
    logic [CW-1:0]              area_idx;

    assign pready  = 1'b1;
    assign cfg_sel = paddr[ggbi_pkg::PADDR_W-1:2] == ggbi_pkg::ADDR_AREA_COUNT[ggbi_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_count_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            area_count_reg <= pwdata[ggbi_pkg::CNT_W-1:0];
        end
    end

    assign prdata = cfg_sel ? 32'(area_count_reg) : '0;

    ggbi_ctrl #(
        .AREAS (AREAS),
        .CW    (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .opcode   (opcode),
        .stat     (stat),
        .cmd      (cmd),
        .area_idx (area_idx),
        .busy     (busy)
    );

    ggbi_dp #(
        .AREAS           (AREAS),
        .AREA_WORDS_LOG2 (AREA_WORDS_LOG2),
        .AW              (AW),
        .CW              (CW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .area_idx       (area_idx),
        .stat           (stat),
        .area_count     (area_count_reg),
        .opcode         (opcode),
        .query_lon      (query_lon),
        .query_lat      (query_lat),
        .area_select    (area_select),
        .origin_lon     (origin_lon),
        .origin_lat     (origin_lat),
        .column_count   (column_count),
        .row_count      (row_count),
        .column_spacing (column_spacing),
        .row_spacing    (row_spacing),
        .word_address   (word_address),
        .word_value     (word_value),
        .done           (done),
        .status         (status),
        .height_mm      (height_mm),
        .area_hit       (area_hit)
    );

endmodule

`default_nettype wire

// ----- verif/geoid_grid_bilinear_interpolator_tb.sv -----
// Self-checking bench for geoid_grid_bilinear_interpolator: grid word and area loads,
// point queries and area_count settings, checked against an in-bench predictor.
// Depends on ggbi_pkg and the top level geoid_grid_bilinear_interpolator.
`timescale 1ns / 1ps

module geoid_grid_bilinear_interpolator_tb;

    localparam int  REGION_LOG2  = ggbi_pkg::AREA_WORDS_LOG2_DEF;
    localparam int  NAREAS       = ggbi_pkg::AREAS_DEF;
    localparam longint ONE_DEG   = 64'sd1 << 22;
    localparam int  CYCLE_LIMIT  = 3000000;

    typedef struct {
        ggbi_pkg::opcode_t                   op;
        logic signed [31:0]                  qlon;
        logic signed [31:0]                  qlat;
        logic [1:0]                          sel;
        logic signed [31:0]                  olon;
        logic signed [31:0]                  olat;
        logic [ggbi_pkg::COL_W-1:0]          ncol;
        logic [ggbi_pkg::COL_W-1:0]          nrow;
        logic [ggbi_pkg::STEP_W-1:0]         dlon;
        logic [ggbi_pkg::STEP_W-1:0]         dlat;
        logic [ggbi_pkg::WADDR_W-1:0]        waddr;
        logic signed [31:0]                  wval;
    } load_or_query_t;

    typedef struct {
        ggbi_pkg::res_t     st;
        logic signed [31:0] mm;
        logic [1:0]         hit;
    } correction_t;

    class geoid_model;
        int unsigned       area_count;
        bit                valid[NAREAS];
        longint            west[NAREAS], east[NAREAS], south[NAREAS], north[NAREAS];
        longint unsigned   lon_step[NAREAS], lat_step[NAREAS], cols[NAREAS];
        int                grid_words[longint unsigned];
        correction_t       pending_corrections[$];
        int                errors;

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Find the serving area and the cell base; fx/fy are Q0.16 fractions.
        function void locate(longint x, longint y, output int idx,
                             output ggbi_pkg::res_t st,
                             output longint unsigned base, output longint unsigned fx,
                             output longint unsigned fy);
            int n;
            longint unsigned dxq, dyq;
            n   = (area_count < NAREAS) ? area_count : NAREAS;
            idx = 0;
            st  = ggbi_pkg::RES_OUT;
            base = 0; fx = 0; fy = 0;
            for (int i = 0; i < n; i++)
            begin
                if (!valid[i] || !(west[i] < x && x < east[i]) ||
                    !(south[i] < y && y < north[i]))
                    continue;
                dxq  = x - west[i];
                dyq  = y - south[i];
                fx   = ((dxq % lon_step[i]) << 16) / lon_step[i];
                fy   = ((dyq % lat_step[i]) << 16) / lat_step[i];
                base = (dyq / lat_step[i] + 1) * (cols[i] + 1) + dxq / lon_step[i] + 1;
                idx  = i;
                st   = (base + cols[i] + 2 >= (64'd1 << REGION_LOG2)) ?
                       ggbi_pkg::RES_RANGE : ggbi_pkg::RES_OK;
                return;
            end
        endfunction

        function longint word_at(int idx, longint unsigned a);
            longint unsigned k;
            k = (longint'(idx) << REGION_LOG2) | a;
            return grid_words.exists(k) ? grid_words[k] : 0;
        endfunction

        function correction_t interpolate(load_or_query_t it);
            correction_t r;
            int idx;
            longint unsigned base, fx, fy, mag, rnd;
            longint t1, t2, t3, t4, u, v, w;
            r.st = ggbi_pkg::RES_LOAD; r.mm = 0; r.hit = 0;
            case (it.op)
                ggbi_pkg::OP_WORD:
                    grid_words[(longint'(it.sel) << REGION_LOG2) | it.waddr] = it.wval;
                ggbi_pkg::OP_DESC:
                begin
                    west[it.sel]     = it.olon;
                    south[it.sel]    = it.olat;
                    east[it.sel]     = sat32(longint'(it.olon) +
                                       (longint'(it.ncol) - 1) * longint'(it.dlon) - ONE_DEG);
                    north[it.sel]    = sat32(longint'(it.olat) +
                                       (longint'(it.nrow) - 1) * longint'(it.dlat));
                    lon_step[it.sel] = it.dlon;
                    lat_step[it.sel] = it.dlat;
                    cols[it.sel]     = it.ncol;
                    valid[it.sel]    = (it.dlon != 0) && (it.dlat != 0);
                end
                ggbi_pkg::OP_QUERY:
                begin
                    locate(it.qlon, it.qlat, idx, r.st, base, fx, fy);
                    r.hit = idx;
                    if (r.st != ggbi_pkg::RES_OK)
                        r.mm = ggbi_pkg::FAIL_MM;
                    else
                    begin
                        t1 = word_at(idx, base);
                        t3 = word_at(idx, base + 1);
                        t2 = word_at(idx, base + cols[idx] + 1);
                        t4 = word_at(idx, base + cols[idx] + 2);
                        u = t1 * (65536 - longint'(fx)) + t3 * longint'(fx);
                        v = t2 * (65536 - longint'(fx)) + t4 * longint'(fx);
                        w = u * (65536 - longint'(fy)) + v * longint'(fy);
                        mag = (w < 0) ? 64'd0 - longint'(w) : w;
                        rnd = (mag + (64'd1 << 39)) >> 40;
                        r.mm = (w < 0) ? -longint'(rnd) : longint'(rnd);
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_accepted(load_or_query_t it);
            pending_corrections.push_back(interpolate(it));
        endfunction

        function void check_result(ggbi_pkg::res_t st, logic signed [31:0] mm,
                                   logic [1:0] hit);
            correction_t e;
            if (pending_corrections.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status %0d height %0d area %0d",
                         $time, st, mm, hit);
                return;
            end
            e = pending_corrections.pop_front();
            if (e.st != st)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.st, st);
            end
            if (e.mm !== mm)
            begin
                errors++;
                $display("%0t: height_mm expected %0d actual %0d", $time, e.mm, mm);
            end
            if (e.hit !== hit)
            begin
                errors++;
                $display("%0t: area_hit expected %0d actual %0d", $time, e.hit, hit);
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel, penable, pwrite;
    logic [ggbi_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          start;
    logic                          busy;
    logic [1:0]                    opcode;
    logic signed [31:0]            query_lon, query_lat, origin_lon, origin_lat, word_value;
    logic [1:0]                    area_select;
    logic [ggbi_pkg::COL_W-1:0]    column_count, row_count;
    logic [ggbi_pkg::STEP_W-1:0]   column_spacing, row_spacing;
    logic [ggbi_pkg::WADDR_W-1:0]  word_address;
    logic                          done;
    logic [1:0]                    status;
    logic signed [31:0]            height_mm;
    logic [1:0]                    area_hit;

    geoid_model model = new();
    int         cycles = 0;
    bit         no_gaps;

    geoid_grid_bilinear_interpolator u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .opcode(opcode),
        .query_lon(query_lon), .query_lat(query_lat), .area_select(area_select),
        .origin_lon(origin_lon), .origin_lat(origin_lat),
        .column_count(column_count), .row_count(row_count),
        .column_spacing(column_spacing), .row_spacing(row_spacing),
        .word_address(word_address), .word_value(word_value),
        .done(done), .status(status), .height_mm(height_mm), .area_hit(area_hit)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("geoid_grid_bilinear_interpolator_tb: errors");
            $finish;
        end
    end

    always @(negedge clk)
        if (rst_n && done)
            model.check_result(ggbi_pkg::res_t'(status), height_mm, area_hit);

    function automatic load_or_query_t random_item(ggbi_pkg::opcode_t op);
        load_or_query_t it;
        it.op    = op;
        it.qlon  = $urandom;
        it.qlat  = $urandom;
        it.sel   = 2'($urandom);
        it.olon  = $urandom;
        it.olat  = $urandom;
        it.ncol  = ggbi_pkg::COL_W'($urandom);
        it.nrow  = ggbi_pkg::COL_W'($urandom);
        it.dlon  = ggbi_pkg::STEP_W'($urandom);
        it.dlat  = ggbi_pkg::STEP_W'($urandom);
        it.waddr = ggbi_pkg::WADDR_W'($urandom);
        it.wval  = $urandom;
        return it;
    endfunction

    // Entered and left just after a rising edge; start stays high when no gap follows.
    task automatic send(load_or_query_t it);
        int gap;
        start          <= 1'b1;
        opcode         <= it.op;
        query_lon      <= it.qlon;
        query_lat      <= it.qlat;
        area_select    <= it.sel;
        origin_lon     <= it.olon;
        origin_lat     <= it.olat;
        column_count   <= it.ncol;
        row_count      <= it.nrow;
        column_spacing <= it.dlon;
        row_spacing    <= it.dlat;
        word_address   <= it.waddr;
        word_value     <= it.wval;
        do @(negedge clk); while (busy);
        @(posedge clk);
        model.note_accepted(it);
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_word(int idx, longint unsigned a, logic signed [31:0] val);
        load_or_query_t it;
        it       = random_item(ggbi_pkg::OP_WORD);
        it.sel   = idx;
        it.waddr = a;
        it.wval  = val;
        send(it);
    endtask

    // Load any corner word the query would read that is still unwritten, then query.
    task automatic send_query(logic signed [31:0] x, logic signed [31:0] y);
        load_or_query_t it;
        int idx;
        ggbi_pkg::res_t st;
        longint unsigned base, fx, fy, corner;
        model.locate(x, y, idx, st, base, fx, fy);
        if (st == ggbi_pkg::RES_OK)
            for (int c = 0; c < 4; c++)
            begin
                corner = base + ((c >= 2) ? model.cols[idx] + 1 : 0) + (c % 2);
                if (!model.grid_words.exists((longint'(idx) << REGION_LOG2) | corner))
                    send_word(idx, corner, $urandom_range(0, 1) ? $urandom
                              : $urandom_range(0, 200000) - 100000);
            end
        it      = random_item(ggbi_pkg::OP_QUERY);
        it.qlon = x;
        it.qlat = y;
        send(it);
    endtask

    task automatic send_desc(int idx, longint ox, longint oy, int nc, int nr,
                             longint unsigned dx, longint unsigned dy);
        load_or_query_t it;
        it      = random_item(ggbi_pkg::OP_DESC);
        it.sel  = idx;
        it.olon = ox;
        it.olat = oy;
        it.ncol = nc;
        it.nrow = nr;
        it.dlon = dx;
        it.dlat = dy;
        send(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (model.pending_corrections.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_area_count(int unsigned v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ggbi_pkg::ADDR_AREA_COUNT;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        model.area_count = v & 7;
    endtask

    task automatic random_traffic(int items);
        int pick, idx, nc;
        longint span_x, span_y;
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, NAREAS - 1);
            if (n == items / 2)
                drain();
            if (pick < 8)
            begin
                nc = $urandom_range(2, 12);
                send_desc(idx, $signed($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000,
                          $signed($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000,
                          nc, $urandom_range(2, 12),
                          $urandom_range((1 << 22) / (nc - 1) + 1024, 1 << 23),
                          $urandom_range(1 << 12, 1 << 23));
            end
            else if (pick < 11)
                send(random_item(ggbi_pkg::OP_DESC));
            else if (pick < 18)
                send(random_item(ggbi_pkg::OP_WORD));
            else if (pick < 21)
                send(random_item(ggbi_pkg::OP_NONE));
            else if (pick < 33)
                send_query($urandom, $urandom);
            else
            begin
                span_x = model.east[idx] - model.west[idx];
                span_y = model.north[idx] - model.south[idx];
                if (model.valid[idx] && span_x >= 2 && span_y >= 2)
                    send_query(model.west[idx] + 1 + ($urandom % (span_x - 1)),
                               model.south[idx] + 1 + ($urandom % (span_y - 1)));
                else
                    send_query($urandom, $urandom);
            end
        end
    endtask

    initial
    begin
        int unsigned counts[9];
        counts  = '{4, 0, 1, 2, 3, 4, 5, 7, 4};
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        start   <= 1'b0;
        opcode  <= ggbi_pkg::OP_NONE;
        query_lon <= '0; query_lat <= '0; area_select <= '0;
        origin_lon <= '0; origin_lat <= '0; column_count <= '0; row_count <= '0;
        column_spacing <= '0; row_spacing <= '0; word_address <= '0; word_value <= '0;
        no_gaps = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes and special cases with no area searched yet.
        send_word(0, 0, 32'sh7fff_ffff);
        send_word(3, 262143, 32'sh8000_0000);
        send(random_item(ggbi_pkg::OP_NONE));
        send_query(0, 0);
        drain();
        write_area_count(4);
        // Small area, zero spacing, a grid beyond its region, a saturated one.
        send_desc(0, -10 * ONE_DEG, 40 * ONE_DEG, 8, 6, 1 << 21, 1 << 21);
        send_desc(1, 0, 0, 8, 8, 0, 1 << 20);
        send_desc(2, 0, 0, 4095, 4095, 1 << 10, 1 << 10);
        send_desc(3, -64'sd2147483648, -64'sd2147483648, 4095, 4095,
                  31'h7fff_ffff, 31'h7fff_ffff);
        send_query(-9 * ONE_DEG, 41 * ONE_DEG + 12345);
        send_query(-10 * ONE_DEG, 41 * ONE_DEG);
        send_query(-10 * ONE_DEG + 1, 40 * ONE_DEG + 1);
        send_query((50 << 10) + 5, (100 << 10) + 7);
        send_query(32'sh7fff_ffff, 32'sh7fff_ffff);
        send_query(32'sh8000_0001, 32'sh8000_0001);
        send_desc(1, 0, 0, 0, 1, 31'h7fff_ffff, 31'h7fff_ffff);
        send_desc(1, 5 * ONE_DEG, 5 * ONE_DEG, 4095, 2, 1, 0);
        send_query(5 * ONE_DEG + 3, 5 * ONE_DEG + 3);
        drain();

        foreach (counts[p])
        begin
            write_area_count(counts[p]);
            no_gaps = (p % 3 == 1);
            random_traffic(67);
            drain();
        end

        if (model.errors == 0 && model.pending_corrections.size() == 0)
            $display("geoid_grid_bilinear_interpolator_tb: clean");
        else
            $display("geoid_grid_bilinear_interpolator_tb: errors");
        $finish;
    end

endmodule
